>>> design/mexp_pkg.sv
`default_nettype none
package mexp_pkg;
  localparam int unsigned WIDTH = 32;
  localparam int unsigned CNT_W = $clog2(WIDTH + 1);
  localparam logic [WIDTH-1:0] MODULUS_RESET = WIDTH'(32'd1000000007);
endpackage
`default_nettype wire

>>> design/modular_exponentiation.sv
// Modular exponentiation, base ** exponent mod modulus, by right-to-left
// square-and-multiply. Pulse start with base and exponent while busy is
// low. For a nonzero exponent busy rises on the next cycle and falls
// as power_mod is presented with done high for exactly one cycle. The
// receiver cannot stall, so capture the word whenever done is high. An
// exponent of zero gives 1 (even for modulus 1). A modulus of zero acts as 2**32.
// One shared shift-and-add modular multiplier does every product, one
// multiplier bit per cycle, with a dispatch step between products. The base
// is first reduced by a bit-serial remainder that runs on the same unit.
// Each set exponent bit then costs one product, and each bit below the top
// set bit costs one squaring. Smaller exponents finish sooner: the cost
// follows the top set bit and the number of set bits. A zero exponent
// raises done in the cycle right after start is accepted, and busy stays
// low. Write modulus (modulus_we / modulus_wdata) only while busy is low.
`default_nettype none
module modular_exponentiation
  import mexp_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [31:0]      base,
  input  wire logic [31:0]      exponent,
  output logic                  busy,
  output logic                  done,
  output logic [31:0]           power_mod,
  input  wire logic             modulus_we,
  input  wire logic [31:0]      modulus_wdata
);

  typedef enum logic [2:0] {
    S_IDLE, S_RED, S_MUL, S_SQR, S_NEXT
  } state_t;

  state_t           state;
  logic [WIDTH-1:0] modulus;
  logic [WIDTH-1:0] sq, acc, ebits;
  logic [WIDTH-1:0] ma, mb, r;   // shared unit: r = ma*mb mod m (or remainder)
  logic [CNT_W-1:0] cnt;

  // One step of r = 2r + bit*ma (mod m), values kept below m; m==0 means 2^W.
  logic [WIDTH:0]   dbl, dsum;
  logic [WIDTH-1:0] r_dbl, r_add;
  logic             mz;
  logic             mbit;

  assign mz   = (modulus == '0);
  assign mbit = mb[WIDTH-1];
  always_comb begin
    dbl   = {r, 1'b0};
    if (!mz && dbl >= {1'b0, modulus}) dbl = dbl - {1'b0, modulus};
    r_dbl = dbl[WIDTH-1:0];
    dsum  = {1'b0, r_dbl} + {1'b0, ma};
    if (!mz && dsum >= {1'b0, modulus}) dsum = dsum - {1'b0, modulus};
    r_add = dsum[WIDTH-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      busy    <= 1'b0;
      done    <= 1'b0;
      modulus <= MODULUS_RESET;
    end else begin
      done <= 1'b0;
      if (modulus_we) modulus <= modulus_wdata[WIDTH-1:0];
      unique case (state)
        S_IDLE: begin
          if (start) begin
            ebits <= exponent[WIDTH-1:0];
            if (exponent[WIDTH-1:0] == '0) begin
              power_mod <= 32'd1;
              done      <= 1'b1;
            end else begin
              // base mod m as 1*base: multiplier bits = base, addend = 1 mod m
              busy  <= 1'b1;
              acc   <= (modulus == WIDTH'(1)) ? '0 : WIDTH'(1);
              ma    <= (modulus == WIDTH'(1)) ? '0 : WIDTH'(1);
              mb    <= base[WIDTH-1:0];
              r     <= '0;
              cnt   <= CNT_W'(WIDTH);
              state <= S_RED;
            end
          end
        end
        S_RED, S_MUL, S_SQR: begin
          r   <= mbit ? r_add : r_dbl;
          mb  <= {mb[WIDTH-2:0], 1'b0};
          cnt <= cnt - 1'b1;
          if (cnt == CNT_W'(1)) begin
            priority case (state)
              S_RED: sq  <= mbit ? r_add : r_dbl;
              S_MUL: acc <= mbit ? r_add : r_dbl;
              default: sq <= mbit ? r_add : r_dbl;
            endcase
            state <= S_NEXT;
          end
        end
        S_NEXT: begin
          // dispatch: multiply acc by sq if bit set, else square or finish
          if (ebits == '0) begin
            power_mod <= 32'(acc);
            done      <= 1'b1;
            busy      <= 1'b0;
            state     <= S_IDLE;
          end else begin
            r   <= '0;
            cnt <= CNT_W'(WIDTH);
            mb  <= sq;
            if (ebits[0]) begin
              ma       <= acc;
              ebits[0] <= 1'b0;
              state    <= S_MUL;
            end else begin
              ma    <= sq;
              ebits <= ebits >> 1;
              if ((ebits >> 1) == '0) begin
                power_mod <= 32'(acc);
                done      <= 1'b1;
                busy      <= 1'b0;
                state     <= S_IDLE;
              end else begin
                state <= S_SQR;
              end
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

>>> design/modular_exponentiation_checker.sv
`default_nettype none
module modular_exponentiation_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        start,
  input wire logic [31:0] exponent,
  input wire logic        busy,
  input wire logic        done,
  input wire logic [31:0] power_mod
);
  a_zero_exp: assert property (@(posedge clk) disable iff (rst)
    start && !busy && exponent == 32'd0 |=> done && power_mod == 32'd1)
    else $error("zero exponent must give 1");
  a_busy_go: assert property (@(posedge clk) disable iff (rst)
    start && !busy && exponent != 32'd0 |=> busy && !done)
    else $error("nonzero exponent must start work");
  // a zero-exponent word taken during done answers on the very next cycle
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done && !(start && !busy && exponent == 32'd0) |=> !done)
    else $error("done longer than one cycle");
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("done while busy");
endmodule

bind modular_exponentiation modular_exponentiation_checker u_chk (
  .clk(clk), .rst(rst), .start(start), .exponent(exponent),
  .busy(busy), .done(done), .power_mod(power_mod)
);
`default_nettype wire

>>> verif/modular_exponentiation_checker.sv
`default_nettype none
module modular_exponentiation_monitor
  import mexp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic        busy,
  input  wire logic [31:0] base,
  input  wire logic [31:0] exponent,
  input  wire logic        done,
  input  wire logic [31:0] power_mod,
  input  wire logic        modulus_we,
  input  wire logic [31:0] modulus_wdata,
  output int               fail_count,
  output int               pending
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [31:0] cur_modulus;
  // small ring of predicted words; at most one is ever outstanding
  logic [31:0] exp_mem[4];
  logic [1:0]  wr_ptr, rd_ptr;
  logic [2:0]  fill;

  // (a + b) mod m, operands already below m
  function automatic logic [63:0] add_m(logic [63:0] a, logic [63:0] b,
                                        logic [63:0] m);
    logic [63:0] room;
    room = m - b;
    return (a >= room) ? a - room : a + b;
  endfunction

  function automatic logic [63:0] mul_m(logic [63:0] a, logic [63:0] b,
                                        logic [63:0] m);
    logic [63:0] r;
    r = 0;
    if (m == 0) return (a * b) & 64'hFFFF_FFFF;
    for (int i = WIDTH - 1; i >= 0; i--) begin
      r = add_m(r, r, m);
      if (b[i]) r = add_m(r, a, m);
    end
    return r;
  endfunction

  function automatic logic [31:0] power_of(logic [31:0] b, logic [31:0] e,
                                           logic [31:0] m);
    logic [63:0] sq, acc, mm;
    logic [31:0] ee;
    mm = m;
    ee = e;
    if (ee == 0) return 32'd1;
    sq = b;
    acc = 1;
    if (mm != 0) begin
      sq = sq % mm;
      acc = 64'd1 % mm;
    end
    while (ee != 0) begin
      if (ee[0]) acc = mul_m(acc, sq, mm);
      ee = ee >> 1;
      if (ee != 0) sq = mul_m(sq, sq, mm);
    end
    return acc[31:0];
  endfunction

  assign pending = int'(fill);

  always @(posedge clk) begin
    if (rst) begin
      cur_modulus <= MODULUS_RESET;
      fail_count <= 0;
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill <= '0;
    end else begin
      if (done) begin
        if (fill == 3'd0) begin
          $display("%0t: unexpected word power_mod=%0d", $time, power_mod);
          fail_count <= fail_count + 1;
        end else begin
          if (exp_mem[rd_ptr] !== power_mod) begin
            $display("%0t: power_mod expected %0d actual %0d",
                     $time, exp_mem[rd_ptr], power_mod);
            fail_count <= fail_count + 1;
          end
          rd_ptr <= rd_ptr + 1'b1;
        end
      end
      if (start && !busy) begin
        exp_mem[wr_ptr] <= power_of(base, exponent, cur_modulus);
        wr_ptr <= wr_ptr + 1'b1;
      end
      fill <= fill + 3'(start && !busy) - 3'(done && fill != 3'd0);
      if (modulus_we) cur_modulus <= modulus_wdata;
    end
  end
endmodule
`default_nettype wire

>>> verif/modular_exponentiation_tb.sv
`default_nettype none
module modular_exponentiation_tb;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk = 0;
  logic        rst = 1;
  logic        start = 0;
  logic [31:0] base = 0;
  logic [31:0] exponent = 0;
  logic        busy, done;
  logic [31:0] power_mod;
  logic        modulus_we = 0;
  logic [31:0] modulus_wdata = 0;
  int          fail_count, pending;
  longint      cycles = 0;
  int          idle_pct;

  // limit covers ~300 worst-case words plus gaps, taken several times over
  localparam longint CYCLE_LIMIT = 3_000_000;

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  modular_exponentiation dut (
    .clk, .rst, .start, .base, .exponent, .busy, .done, .power_mod,
    .modulus_we, .modulus_wdata
  );

  modular_exponentiation_monitor chk (
    .clk, .rst, .start, .busy, .base, .exponent, .done, .power_mod,
    .modulus_we, .modulus_wdata, .fail_count, .pending
  );

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("modular_exponentiation_tb: done, errors");
      $finish;
    end
  end

  // one word: present at falling edge, hold until accepted (start && !busy);
  // start stays high on return so the next word can follow with no gap
  task automatic send_word(logic [31:0] b, logic [31:0] e);
    while ($urandom_range(99) < idle_pct) begin
      start <= 0;
      @(negedge clk);
    end
    start <= 1;
    base <= b;
    exponent <= e;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
  endtask

  // stop sending and wait until every expected word has come back
  task automatic drain();
    start <= 0;
    @(negedge clk);
    while (pending != 0 || busy) @(negedge clk);
    repeat (5) @(negedge clk);
  endtask

  task automatic set_modulus(logic [31:0] m);
    drain();
    modulus_we <= 1;
    modulus_wdata <= m;
    @(negedge clk);
    modulus_we <= 0;
  endtask

  // mostly short exponents keep the run fast; some full-width ones
  function automatic logic [31:0] rand_exp();
    int k;
    k = $urandom_range(99);
    if (k < 5) return 0;
    if (k < 15) return $urandom;
    if (k < 20) return 32'hFFFF_FFFF >> $urandom_range(31);
    return $urandom_range(255);
  endfunction

  function automatic logic [31:0] rand_base();
    int k;
    k = $urandom_range(9);
    if (k == 0) return 0;
    if (k == 1) return 32'hFFFF_FFFF;
    if (k == 2) return $urandom_range(3);
    return $urandom;
  endfunction

  initial begin
    logic [31:0] mods[6];
    mods = '{32'd1000000007, 32'd1, 32'hFFFF_FFFF, 32'd0, 32'd97, 32'h8000_0001};
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    idle_pct = 0;

    // directed: reset modulus in effect
    send_word(0, 0);
    send_word(32'hFFFF_FFFF, 0);
    send_word(2, 10);
    send_word(0, 5);
    send_word(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_word(32'd1000000007, 3);
    send_word(32'd1000000008, 32'h8000_0000);
    send_word(3, 1);
    // modulus one: zero exponent still gives one
    set_modulus(1);
    send_word(5, 0);
    send_word(5, 7);
    // modulus zero wraps at 2^32
    set_modulus(0);
    send_word(3, 32'hFFFF_FFFF);
    send_word(32'hFFFF_FFFF, 2);
    send_word(2, 32);
    // largest modulus, base at and below it
    set_modulus(32'hFFFF_FFFF);
    send_word(32'hFFFF_FFFF, 9);
    send_word(32'hFFFF_FFFE, 32'hAAAA_AAAA);
    send_word(32'h5555_5555, 32'h5555_5555);

    // random phases cycle through idling profiles and modulus settings
    for (int ph = 0; ph < 12; ph++) begin
      set_modulus(ph % 2 ? $urandom : mods[ph % 6]);
      idle_pct = (ph < 4) ? 36 : (ph < 8) ? 62 : 0;
      for (int i = 0; i < 22; i++) send_word(rand_base(), rand_exp());
      // sender holds off until everything has come back
      if (ph == 5) drain();
    end

    drain();
    repeat (20) @(posedge clk);
    if (fail_count == 0) $display("modular_exponentiation_tb: done, clean");
    else $display("modular_exponentiation_tb: done, errors");
    $finish;
  end
endmodule
`default_nettype wire
